// File: rtl/dps_pkg.sv
// Package for the DMA page burst splitter: constants, types and sequencer program.
`default_nettype none

package dps_pkg;

  localparam int unsigned PAGE_BYTES      = 4096;
  localparam int unsigned PAGE_LOG2       = $clog2(PAGE_BYTES);
  localparam int unsigned MAX_PAGE_COUNT  = 524288;
  localparam int unsigned MAX_BURST_BEATS = 256;
  localparam int unsigned MAX_RESULTS     = 16;

  localparam int unsigned FRAME_W = 36;
  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned UNIT_W  = 3;
  localparam int unsigned BM1_W   = 8;
  localparam int unsigned LEN_W   = PAGE_LOG2 + 1;
  localparam int unsigned TAKE_W  = $clog2(MAX_BURST_BEATS) + 1;
  localparam int unsigned CNT_W   = $clog2(MAX_RESULTS);
  localparam int unsigned MASK_W  = (1 << UNIT_W) - 1;

  localparam logic [UNIT_W-1:0] UNIT_LOG2_RESET = UNIT_W'(4);
  localparam logic [SIZE_W:0]   MAX_TRANSFER_BYTES =
      (SIZE_W+1)'(MAX_PAGE_COUNT) * (SIZE_W+1)'(PAGE_BYTES);

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_ALIGN = 2'd1,
    ERR_SIZE  = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PREP,
    S_BURST,
    S_ERR
  } step_e;

  typedef enum logic [2:0] {
    COND_IN_VALID,
    COND_CHK_ERR,
    COND_SKIP,
    COND_BURST_DONE,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic  in_ready;
    logic  check;
    logic  prep;
    logic  emit_burst;
    logic  emit_err;
    cond_e cond;
    step_e jump;
    step_e next;
  } ctl_t;

  // Sequencer program: jump when the condition holds, else go to next.
  function automatic ctl_t seq_rom(step_e s);
    ctl_t w;
    w = '{in_ready: 1'b0, check: 1'b0, prep: 1'b0, emit_burst: 1'b0, emit_err: 1'b0,
          cond: COND_IN_VALID, jump: S_IDLE, next: S_IDLE};
    case (s)
      S_IDLE: begin
        w.in_ready = 1'b1;
        w.cond     = COND_IN_VALID;
        w.jump     = S_CHECK;
        w.next     = S_IDLE;
      end
      S_CHECK: begin
        w.check = 1'b1;
        w.cond  = COND_CHK_ERR;
        w.jump  = S_ERR;
        w.next  = S_PREP;
      end
      S_PREP: begin
        w.prep = 1'b1;
        w.cond = COND_SKIP;
        w.jump = S_IDLE;
        w.next = S_BURST;
      end
      S_BURST: begin
        w.emit_burst = 1'b1;
        w.cond       = COND_BURST_DONE;
        w.jump       = S_IDLE;
        w.next       = S_BURST;
      end
      S_ERR: begin
        w.emit_err = 1'b1;
        w.cond     = COND_OUT_FREE;
        w.jump     = S_IDLE;
        w.next     = S_ERR;
      end
      default: begin
        w.cond = COND_IN_VALID;
        w.jump = S_IDLE;
        w.next = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dma_page_burst_splitter.sv
// DMA page burst splitter: microcoded sequencer that cuts page frames into bursts.
`default_nettype none

// Each accepted page frame transaction runs through a small program: accept, check the
// transfer start, set up the page, then one burst per cycle while the output register
// can take it, up to 16 bursts per page. An error goes from the check to an error step
// that issues its one result. A page with nothing left to move returns to idle after
// the set-up step, and one whose length rounds down to zero beats after unit_log2 was
// widened mid transfer also passes through the burst step without a result. The burst
// step issues through a single output register, which sets the pace under backpressure.
// unit_log2 may be rewritten between transactions through cfg_we_i / cfg_wdata_i.
module dma_page_burst_splitter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dps_pkg::UNIT_W-1:0]      cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            first_page_i,
  input  wire logic [dps_pkg::PAGE_LOG2-1:0]   start_offset_i,
  input  wire logic [dps_pkg::SIZE_W-1:0]      transfer_size_i,
  input  wire logic [dps_pkg::FRAME_W-1:0]     page_frame_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [dps_pkg::ADDR_W-1:0]           burst_address_o,
  output logic [dps_pkg::BM1_W-1:0]            beats_minus_one_o,
  output logic [1:0]                           error_code_o,
  output logic                                 last_of_page_o,
  output logic                                 last_of_transfer_o
);

  dps_pkg::step_e step_q, step_d;
  dps_pkg::ctl_t  ctl;

  logic [dps_pkg::UNIT_W-1:0]    unit_q;
  logic                          first_q;
  logic [dps_pkg::PAGE_LOG2-1:0] offs_q;
  logic [dps_pkg::SIZE_W-1:0]    size_q;
  logic [dps_pkg::FRAME_W-1:0]   frame_q;
  dps_pkg::err_e                 err_q;

  logic [dps_pkg::SIZE_W-1:0]    remaining_q;
  logic [dps_pkg::PAGE_LOG2-1:0] page_offset_q;
  logic                          aborted_q;

  logic [dps_pkg::LEN_W-1:0]     beats_q;
  logic [dps_pkg::ADDR_W-1:0]    addr_q;
  logic [dps_pkg::CNT_W-1:0]     burst_cnt_q;

  logic                          out_valid_q;
  logic [dps_pkg::ADDR_W-1:0]    out_addr_q;
  logic [dps_pkg::BM1_W-1:0]     out_bm1_q;
  dps_pkg::err_e                 out_err_q;
  logic                          out_lp_q;
  logic                          out_lt_q;

  logic                          in_fire;
  logic                          slot_free;
  logic [dps_pkg::MASK_W-1:0]    unit_mask;
  logic                          over_limit;
  logic                          misaligned;
  logic                          chk_err;
  logic                          skip;
  logic [dps_pkg::LEN_W-1:0]     avail;
  logic [dps_pkg::LEN_W-1:0]     len;
  logic [dps_pkg::TAKE_W-1:0]    take;
  logic                          burst_last;
  logic                          burst_done;
  logic                          emit;
  logic                          emit_e;
  logic                          cond_true;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= dps_pkg::S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    ctl = dps_pkg::seq_rom(step_q);
    case (ctl.cond)
      dps_pkg::COND_IN_VALID:   cond_true = in_valid_i;
      dps_pkg::COND_CHK_ERR:    cond_true = chk_err;
      dps_pkg::COND_SKIP:       cond_true = skip;
      dps_pkg::COND_BURST_DONE: cond_true = burst_done;
      dps_pkg::COND_OUT_FREE:   cond_true = slot_free;
      default:                  cond_true = 1'b1;
    endcase
    step_d = cond_true ? ctl.jump : ctl.next;
  end

  // Datapath
  assign in_ready_o = ctl.in_ready;
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  assign unit_mask  = dps_pkg::MASK_W'((8'd1 << unit_q) - 8'd1);
  assign over_limit = {1'b0, size_q} > dps_pkg::MAX_TRANSFER_BYTES;
  assign misaligned = ((offs_q[dps_pkg::MASK_W-1:0] & unit_mask) != '0) ||
                      ((size_q[dps_pkg::MASK_W-1:0] & unit_mask) != '0);
  assign chk_err    = first_q && (over_limit || misaligned);
  assign skip       = aborted_q || (remaining_q == '0);

  assign avail = dps_pkg::LEN_W'(dps_pkg::PAGE_BYTES) - {1'b0, page_offset_q};
  assign len   = (dps_pkg::SIZE_W'(avail) > remaining_q) ?
                 remaining_q[dps_pkg::LEN_W-1:0] : avail;

  assign take = (beats_q > dps_pkg::LEN_W'(dps_pkg::MAX_BURST_BEATS)) ?
                dps_pkg::TAKE_W'(dps_pkg::MAX_BURST_BEATS) :
                dps_pkg::TAKE_W'(beats_q);
  assign burst_last = (dps_pkg::LEN_W'(take) == beats_q) ||
                      (burst_cnt_q == dps_pkg::CNT_W'(dps_pkg::MAX_RESULTS - 1));
  // A page that rounds to zero beats finishes without a result.
  assign burst_done = (beats_q == '0) || (slot_free && burst_last);
  assign emit       = ctl.emit_burst && (beats_q != '0) && slot_free;
  assign emit_e     = ctl.emit_err && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q        <= dps_pkg::UNIT_LOG2_RESET;
      remaining_q   <= '0;
      page_offset_q <= '0;
      aborted_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unit_q <= cfg_wdata_i;
      end
      if (ctl.check && first_q) begin
        if (chk_err) begin
          remaining_q   <= '0;
          page_offset_q <= '0;
          aborted_q     <= 1'b1;
        end else begin
          remaining_q   <= size_q;
          page_offset_q <= offs_q;
          aborted_q     <= 1'b0;
        end
      end
      if (ctl.prep && !skip) begin
        remaining_q   <= remaining_q - dps_pkg::SIZE_W'(len);
        page_offset_q <= '0;
      end
      if (emit || emit_e) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      first_q <= first_page_i;
      offs_q  <= start_offset_i;
      size_q  <= transfer_size_i;
      frame_q <= page_frame_i;
    end
    if (ctl.check) begin
      err_q <= over_limit ? dps_pkg::ERR_SIZE : dps_pkg::ERR_ALIGN;
    end
    if (ctl.prep) begin
      beats_q     <= len >> unit_q;
      addr_q      <= {frame_q, page_offset_q};
      burst_cnt_q <= '0;
    end
    if (emit) begin
      // Advance to the next burst of this page.
      beats_q     <= beats_q - dps_pkg::LEN_W'(take);
      addr_q      <= addr_q + (dps_pkg::ADDR_W'(take) << unit_q);
      burst_cnt_q <= burst_cnt_q + dps_pkg::CNT_W'(1);
      out_addr_q  <= addr_q;
      out_bm1_q   <= dps_pkg::BM1_W'(take - dps_pkg::TAKE_W'(1));
      out_err_q   <= dps_pkg::ERR_NONE;
      out_lp_q    <= burst_last;
      out_lt_q    <= burst_last && (remaining_q == '0);
    end
    if (emit_e) begin
      out_addr_q <= '0;
      out_bm1_q  <= '0;
      out_err_q  <= err_q;
      out_lp_q   <= 1'b1;
      out_lt_q   <= 1'b1;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign burst_address_o    = out_addr_q;
  assign beats_minus_one_o  = out_bm1_q;
  assign error_code_o       = out_err_q;
  assign last_of_page_o     = out_lp_q;
  assign last_of_transfer_o = out_lt_q;

  // Assertions
  a_err_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != dps_pkg::ERR_NONE) |->
      last_of_page_o && last_of_transfer_o && (beats_minus_one_o == '0))
    else $error("error transaction with wrong flags");

  a_xfer_implies_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_transfer_o |-> last_of_page_o)
    else $error("last of transfer without last of page");

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (step_q == dps_pkg::S_CHECK))
    else $error("accepted transaction not checked");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == dps_pkg::S_BURST) && emit && !burst_last |=>
      (step_q == dps_pkg::S_BURST) && !in_ready_o)
    else $error("burst sequence cut short");

endmodule

`default_nettype wire

// File: tb/dps_burst_checker.sv
// Checker for the DMA page burst splitter: predicts bursts per page and compares results.
`timescale 1ns / 100ps

module dps_burst_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dps_pkg::UNIT_W-1:0]      cfg_wdata_i,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_ready_i,
  input  wire logic                            first_page_i,
  input  wire logic [dps_pkg::PAGE_LOG2-1:0]   start_offset_i,
  input  wire logic [dps_pkg::SIZE_W-1:0]      transfer_size_i,
  input  wire logic [dps_pkg::FRAME_W-1:0]     page_frame_i,
  input  wire logic                            out_valid_i,
  input  wire logic                            out_ready_i,
  input  wire logic [dps_pkg::ADDR_W-1:0]      burst_address_i,
  input  wire logic [dps_pkg::BM1_W-1:0]       beats_minus_one_i,
  input  wire logic [1:0]                      error_code_i,
  input  wire logic                            last_of_page_i,
  input  wire logic                            last_of_transfer_i,
  output int                                   mismatch_count_o,
  output int                                   bursts_due_o
);

  typedef struct packed {
    logic [dps_pkg::ADDR_W-1:0] addr;
    logic [dps_pkg::BM1_W-1:0]  bm1;
    dps_pkg::err_e              err;
    logic                       lp;
    logic                       lt;
  } burst_t;

  burst_t                           bursts_due[$];
  logic [dps_pkg::UNIT_W-1:0]       beat_log2;
  logic [dps_pkg::SIZE_W-1:0]       bytes_left;
  logic [dps_pkg::PAGE_LOG2-1:0]    next_offset;
  logic                             aborted;

  initial begin
    mismatch_count_o = 0;
    bursts_due_o     = 0;
  end

  task automatic note_mismatch(input string what, input burst_t want, input burst_t got);
    mismatch_count_o++;
    if (mismatch_count_o <= 10)
      $display({"%0t %s: expected addr=%h bm1=%0d err=%0d lp=%0b lt=%0b,",
                " got addr=%h bm1=%0d err=%0d lp=%0b lt=%0b"},
               $realtime, what, want.addr, want.bm1, want.err, want.lp, want.lt,
               got.addr, got.bm1, got.err, got.lp, got.lt);
  endtask

  task automatic abort_transfer(input dps_pkg::err_e code);
    burst_t b;
    b = '{addr: '0, bm1: '0, err: code, lp: 1'b1, lt: 1'b1};
    bytes_left  = '0;
    next_offset = '0;
    aborted     = 1'b1;
    bursts_due.push_back(b);
  endtask

  // Work out the bursts that one page transaction causes and queue them.
  task automatic split_page(input logic first, input logic [dps_pkg::PAGE_LOG2-1:0] off,
                            input logic [dps_pkg::SIZE_W-1:0] size,
                            input logic [dps_pkg::FRAME_W-1:0] frame);
    logic [dps_pkg::SIZE_W-1:0]  unit_mask;
    logic [dps_pkg::LEN_W-1:0]   len;
    logic [dps_pkg::LEN_W-1:0]   beats;
    logic [dps_pkg::TAKE_W-1:0]  take;
    logic [dps_pkg::ADDR_W-1:0]  addr;
    burst_t                      b;
    int                          n;
    unit_mask = (dps_pkg::SIZE_W'(1) << beat_log2) - dps_pkg::SIZE_W'(1);
    if (first) begin
      if ({1'b0, size} > dps_pkg::MAX_TRANSFER_BYTES) begin
        abort_transfer(dps_pkg::ERR_SIZE);
        return;
      end
      if (((dps_pkg::SIZE_W'(off) | size) & unit_mask) != '0) begin
        abort_transfer(dps_pkg::ERR_ALIGN);
        return;
      end
      aborted     = 1'b0;
      bytes_left  = size;
      next_offset = off;
    end
    if (aborted || bytes_left == '0)
      return;
    len = dps_pkg::LEN_W'(dps_pkg::PAGE_BYTES) - dps_pkg::LEN_W'(next_offset);
    if (dps_pkg::SIZE_W'(len) > bytes_left)
      len = dps_pkg::LEN_W'(bytes_left);
    beats       = len >> beat_log2;
    addr        = (dps_pkg::ADDR_W'(frame) << dps_pkg::PAGE_LOG2)
                  + dps_pkg::ADDR_W'(next_offset);
    bytes_left  = bytes_left - dps_pkg::SIZE_W'(len);
    next_offset = '0;
    n = 0;
    // Cap the page at the result budget; the last one emitted closes the page.
    while (beats != '0 && n < dps_pkg::MAX_RESULTS) begin
      take   = (beats > dps_pkg::LEN_W'(dps_pkg::MAX_BURST_BEATS))
               ? dps_pkg::TAKE_W'(dps_pkg::MAX_BURST_BEATS) : dps_pkg::TAKE_W'(beats);
      b.addr = addr;
      b.bm1  = dps_pkg::BM1_W'(take - dps_pkg::TAKE_W'(1));
      b.err  = dps_pkg::ERR_NONE;
      b.lp   = (beats == dps_pkg::LEN_W'(take)) || (n == dps_pkg::MAX_RESULTS - 1);
      b.lt   = b.lp && (bytes_left == '0);
      bursts_due.push_back(b);
      n++;
      beats = beats - dps_pkg::LEN_W'(take);
      addr  = addr + (dps_pkg::ADDR_W'(take) << beat_log2);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    burst_t got;
    burst_t want;
    if (!rst_ni) begin
      bursts_due.delete();
      beat_log2    = dps_pkg::UNIT_LOG2_RESET;
      bytes_left   = '0;
      next_offset  = '0;
      aborted      = 1'b0;
      bursts_due_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{addr: burst_address_i, bm1: beats_minus_one_i,
                err: dps_pkg::err_e'(error_code_i), lp: last_of_page_i,
                lt: last_of_transfer_i};
        if (bursts_due.size() == 0) begin
          want = '0;
          note_mismatch("result with none expected", want, got);
        end else begin
          want = bursts_due.pop_front();
          if (got !== want)
            note_mismatch("burst mismatch", want, got);
        end
      end
      if (in_valid_i && in_ready_i)
        split_page(first_page_i, start_offset_i, transfer_size_i, page_frame_i);
      if (cfg_we_i)
        beat_log2 = cfg_wdata_i;
      bursts_due_o = bursts_due.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for the DMA page burst splitter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SEG_PAGES   = 31;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [dps_pkg::UNIT_W-1:0]      cfg_wdata_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic                            first_page_i;
  logic [dps_pkg::PAGE_LOG2-1:0]   start_offset_i;
  logic [dps_pkg::SIZE_W-1:0]      transfer_size_i;
  logic [dps_pkg::FRAME_W-1:0]     page_frame_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [dps_pkg::ADDR_W-1:0]      burst_address_o;
  logic [dps_pkg::BM1_W-1:0]       beats_minus_one_o;
  logic [1:0]                      error_code_o;
  logic                            last_of_page_o;
  logic                            last_of_transfer_o;

  int                              mismatch_count;
  int                              bursts_due;
  int unsigned                     snd_idle_pct;
  int unsigned                     rcv_idle_pct;
  int                              hold_reqs;
  int unsigned                     pages_sent;
  int unsigned                     cycle_count;
  logic [dps_pkg::UNIT_W-1:0]      beat_log2;

  always #2 clk_i = ~clk_i;

  dma_page_burst_splitter i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .first_page_i       (first_page_i),
    .start_offset_i     (start_offset_i),
    .transfer_size_i    (transfer_size_i),
    .page_frame_i       (page_frame_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .burst_address_o    (burst_address_o),
    .beats_minus_one_o  (beats_minus_one_o),
    .error_code_o       (error_code_o),
    .last_of_page_o     (last_of_page_o),
    .last_of_transfer_o (last_of_transfer_o)
  );

  dps_burst_checker i_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .first_page_i       (first_page_i),
    .start_offset_i     (start_offset_i),
    .transfer_size_i    (transfer_size_i),
    .page_frame_i       (page_frame_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .burst_address_i    (burst_address_o),
    .beats_minus_one_i  (beats_minus_one_o),
    .error_code_i       (error_code_o),
    .last_of_page_i     (last_of_page_o),
    .last_of_transfer_i (last_of_transfer_o),
    .mismatch_count_o   (mismatch_count),
    .bursts_due_o       (bursts_due)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[dma_page_burst_splitter] ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold when the stimulus requests one.
  initial begin : result_sink
    int hold_seen;
    int unsigned hold_left;
    hold_seen   = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  function automatic logic [dps_pkg::FRAME_W-1:0] rand_frame();
    return {4'($urandom), $urandom};
  endfunction

  // Offer one page transaction and hold it until accepted; return at a falling edge.
  task automatic send_page(input logic first, input logic [dps_pkg::PAGE_LOG2-1:0] off,
                           input logic [dps_pkg::SIZE_W-1:0] size,
                           input logic [dps_pkg::FRAME_W-1:0] frame);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    first_page_i    <= first;
    start_offset_i  <= off;
    transfer_size_i <= size;
    page_frame_i    <= frame;
    @(posedge clk_i);
    while (!in_ready_o)
      @(posedge clk_i);
    pages_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering, drain every expected burst, let the sequencer settle.
  task automatic drain(input int unsigned settle);
    in_valid_i <= 1'b0;
    while (bursts_due != 0)
      @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic set_beat_width(input logic [dps_pkg::UNIT_W-1:0] log2_bytes);
    drain(8);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= log2_bytes;
    beat_log2    = log2_bytes;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One transfer: mostly well-formed page runs, some cut short, errors and noise.
  task automatic run_transfer();
    int unsigned                    kind;
    int unsigned                    unit;
    int unsigned                    npages;
    longint unsigned                span;
    logic [dps_pkg::PAGE_LOG2-1:0]  off;
    logic [dps_pkg::SIZE_W-1:0]     size;
    kind = $urandom_range(0, 99);
    unit = 1 << beat_log2;
    if (kind < 78) begin
      off = 12'($urandom_range(0, 4095)) & ~12'(unit - 1);
      case ($urandom_range(0, 9))
        0:       size = '0;
        7:       size = 32'(dps_pkg::PAGE_BYTES) - 32'(off);
        8:       size = $urandom & ~32'(unit - 1);
        9:       size = 32'h8000_0000;
        default: size = 32'($urandom_range(1, 12288 / unit)) * 32'(unit);
      endcase
      span   = longint'(off) + longint'(size);
      npages = (span == 0) ? 1 : int'((span + 4095) / 4096);
      if (npages > 4)
        npages = $urandom_range(1, 4);
      else if (npages > 1 && $urandom_range(0, 9) == 0)
        npages = $urandom_range(1, npages - 1);
      send_page(1'b1, off, size, rand_frame());
      for (int i = 1; i < npages; i++)
        send_page(1'b0, 12'($urandom), $urandom, rand_frame());
      if ($urandom_range(0, 4) == 0)
        send_page(1'b0, 12'($urandom), $urandom, rand_frame());
    end else if (kind < 90) begin
      send_page(1'b1, 12'($urandom), $urandom, rand_frame());
      send_page(1'b0, 12'($urandom), $urandom, rand_frame());
    end else begin
      send_page(1'($urandom), 12'($urandom), $urandom, rand_frame());
    end
  endtask

  initial begin : stimulus
    int unsigned seg_start;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    first_page_i    = 1'b0;
    start_offset_i  = '0;
    transfer_size_i = '0;
    page_frame_i    = '0;
    snd_idle_pct    = 34;
    rcv_idle_pct    = 73;
    hold_reqs       = 0;
    pages_sent      = 0;
    cycle_count     = 0;
    beat_log2       = dps_pkg::UNIT_LOG2_RESET;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed pass at the reset beat width of 16 bytes.
    send_page(1'b0, 12'h0,   32'd0,          rand_frame());      // nothing pending
    send_page(1'b1, 12'h0,   32'd4096,       '0);                // one full page
    send_page(1'b1, 12'hFF0, 32'd32,         '1);                // last slot of top frame
    send_page(1'b0, 12'h0,   32'd0,          '0);
    send_page(1'b0, 12'h0,   32'd0,          rand_frame());      // past the end
    send_page(1'b1, 12'h0,   32'hFFFF_FFFF,  rand_frame());      // over limit
    send_page(1'b0, 12'h0,   32'd0,          rand_frame());      // dropped while aborted
    send_page(1'b1, 12'h010, 32'h8000_0010,  rand_frame());      // over limit, aligned
    send_page(1'b1, 12'h010, 32'h8000_0001,  rand_frame());      // over limit beats align
    send_page(1'b1, 12'hFFF, 32'd16,         rand_frame());      // misaligned start
    send_page(1'b1, 12'h0,   32'd17,         rand_frame());      // misaligned size
    send_page(1'b1, 12'h0,   32'd0,          rand_frame());      // empty transfer
    send_page(1'b0, 12'h0,   32'd0,          rand_frame());
    send_page(1'b1, 12'h0,   32'h8000_0000,  rand_frame());      // exactly at the limit
    send_page(1'b0, 12'hABC, 32'h1234_5678,  rand_frame());
    send_page(1'b1, 12'h100, 32'd48,         rand_frame());      // restart mid transfer
    send_page(1'b1, 12'd4000, 32'd12288,     rand_frame());
    send_page(1'b0, 12'h0,   32'd0,          rand_frame());
    send_page(1'b0, 12'h0,   32'd0,          rand_frame());
    send_page(1'b0, 12'h0,   32'd0,          rand_frame());      // closes the transfer

    for (int seg = 0; seg < 6; seg++) begin
      if (seg < 2) begin
        snd_idle_pct = 34;
        rcv_idle_pct = 73;
      end else if (seg < 4) begin
        snd_idle_pct = 73;
        rcv_idle_pct = 34;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case (seg)
        0:       set_beat_width(3'd0);
        1:       set_beat_width(3'd7);
        default: set_beat_width(3'($urandom_range(0, 7)));
      endcase
      // Stall the result side long enough to back up the input.
      if (seg == 4)
        hold_reqs++;
      seg_start = pages_sent;
      while (pages_sent - seg_start < SEG_PAGES)
        run_transfer();
    end

    drain(24);
    if (mismatch_count == 0 && bursts_due == 0)
      $display("[dma_page_burst_splitter] OK");
    else
      $display("[dma_page_burst_splitter] ERROR");
    $finish;
  end

endmodule

// File: dma_page_burst_splitter.f
rtl/dps_pkg.sv
rtl/dma_page_burst_splitter.sv
tb/dps_burst_checker.sv
tb/tb_top.sv
